>>> src/tsb_pkg.sv
// Shared types and constants for the texture sampler.
// No dependencies.
package tsb_pkg;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int DIM_W      = 9;
    localparam int COORD_W    = 20;
    localparam int VALUE_W    = 16;
    localparam int COMP_W     = 2;
    localparam int ADDR_IN_W  = 16;
    localparam int IN_DATA_W  = 80;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMPS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UWRAP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VWRAP  = 3'd5;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef logic [DIM_W-1:0] dim_t;
endpackage

>>> src/tsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> src/texture_sampler_bilinear.sv
// Texture sampler top level: texel store, address generation and filter datapath.
// Depends on tsb_pkg and tsb_ram.
//
// A write transaction stores one component and is taken in its own cycle; the block
// stays ready. A sample transaction runs on one shared multiplier under a sequencer
// and holds ready low until its last result is loaded. Setup scales both coordinates,
// splits them into index and fraction, addresses each axis (with a bit-serial modulo
// when wrap addressing falls outside the texture), forms row bases and weights, and then
// reads and accumulates each component; point mode reads one texel per component and
// bilinear mode four, one at a time through the single read port of the texel store.
module texture_sampler_bilinear
    import tsb_pkg::*;
#(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int MAX_COMPONENTS = 4,
    parameter int WEIGHT_BITS    = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // texel_address[15:0], component_index[17:16], texel_value[33:18],
    // u_coord[53:34], v_coord[73:54], zero[79:74]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // component_value[15:0]
    output logic [VALUE_W-1:0]    m_axis_tdata,
    // component_number[1:0]
    output logic [COMP_W-1:0]     m_axis_tuser,
    output logic                  m_axis_tlast
);
    localparam int TEXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH  = TEXELS * MAX_COMPONENTS;
    localparam int AW     = $clog2(DEPTH);
    localparam int WB     = WEIGHT_BITS;
    localparam int B      = 2 * WB + 1;
    localparam int PW     = 22 + B;
    localparam int AC     = VALUE_W + 2 * WB + 1;
    localparam int SW     = 30;
    localparam int IUW    = SW - 16;
    localparam int RBW    = 2 * DIM_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MU   = 4'd1;
    localparam logic [3:0] S_MV   = 4'd2;
    localparam logic [3:0] S_AY   = 4'd3;
    localparam logic [3:0] S_AX   = 4'd4;
    localparam logic [3:0] S_MOD  = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_RB0  = 4'd7;
    localparam logic [3:0] S_RB1  = 4'd8;
    localparam logic [3:0] S_WG   = 4'd9;
    localparam logic [3:0] S_FA   = 4'd10;
    localparam logic [3:0] S_FD   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // configuration
    logic [CFG_DATA_W-1:0] width_reg, height_reg;
    logic [2:0]            comps_reg;
    logic                  filter_reg, uwrap_reg, vwrap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            comps_reg  <= 3'd4;
            filter_reg <= 1'b0;
            uwrap_reg  <= 1'b0;
            vwrap_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_COMPS:  comps_reg  <= cfg_data[2:0];
                REG_FILTER: filter_reg <= cfg_data[0];
                REG_UWRAP:  uwrap_reg  <= cfg_data[0];
                REG_VWRAP:  vwrap_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    dim_t       w_eff, h_eff;
    logic [2:0] nc_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = 9'd1;
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = 9'd1;
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        if (comps_reg == '0)
            nc_eff = 3'd1;
        else if (32'(comps_reg) > 32'(MAX_COMPONENTS))
            nc_eff = 3'(MAX_COMPONENTS);
        else
            nc_eff = comps_reg;
    end

    function automatic dim_t clamp_idx(input logic signed [IUW:0] i, input dim_t sz);
        dim_t r;
        if (i < 0)
            r = '0;
        else if (i >= $signed({{(IUW+1-DIM_W){1'b0}}, sz}))
            r = sz - 9'd1;
        else
            r = i[DIM_W-1:0];
        return r;
    endfunction

    // sequencer state
    logic [3:0]                  state_reg;
    logic signed [COORD_W-1:0]   u_reg, v_reg;
    logic signed [SW-1:0]        su_reg, sv_reg;
    logic signed [IUW-1:0]       iu_reg [2];
    logic [WB-1:0]               f_reg [2];
    dim_t                        a0_reg [2];
    dim_t                        a1_reg [2];
    logic                        axis_reg;
    logic [IUW-1:0]              mag_reg;
    logic                        neg_reg;
    dim_t                        rem_reg;
    logic [3:0]                  cnt_reg;
    logic [RBW-1:0]              rb_reg [2];
    logic [B-1:0]                wt_reg [4];
    logic [1:0]                  k_reg;
    logic [COMP_W-1:0]           c_reg;
    logic [AC-1:0]               acc_reg;
    logic                        m_valid_reg;
    logic [VALUE_W-1:0]          m_data_reg;
    logic [COMP_W-1:0]           m_num_reg;
    logic                        m_last_reg;

    // shared multiplier
    logic signed [20:0]   op_a;
    logic [B-1:0]         op_b;
    logic signed [PW-1:0] prod;
    logic [WB:0]          one_w, wx, wy;

    assign one_w = (WB+1)'(1) << WB;
    assign wx    = k_reg[0] ? {1'b0, f_reg[0]} : one_w - {1'b0, f_reg[0]};
    assign wy    = k_reg[1] ? {1'b0, f_reg[1]} : one_w - {1'b0, f_reg[1]};

    logic [VALUE_W-1:0] ram_rdata;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_MU:
            begin
                op_a = 21'(u_reg);
                op_b = B'(w_eff);
            end
            S_MV:
            begin
                op_a = 21'(v_reg);
                op_b = B'(h_eff);
            end
            S_RB0:
            begin
                op_a = $signed(21'(a0_reg[1]));
                op_b = B'(w_eff);
            end
            S_RB1:
            begin
                op_a = $signed(21'(a1_reg[1]));
                op_b = B'(w_eff);
            end
            S_WG:
            begin
                op_a = $signed(21'(wx));
                op_b = B'(wy);
            end
            S_FD:
            begin
                op_a = $signed(21'(ram_rdata));
                op_b = wt_reg[k_reg];
            end
            default: ;
        endcase
    end

    assign prod = PW'(op_a * $signed({1'b0, op_b}));

    // split scaled coordinate into integer index and fraction
    logic signed [SW-1:0] sp;
    assign sp = ((state_reg == S_MV) ? su_reg : sv_reg)
              - (filter_reg ? SW'(32768) : SW'(0));

    // per-axis address generation
    logic signed [IUW-1:0] iu_cur;
    dim_t                  size_cur;
    logic                  wrap_cur, in_range;
    logic [DIM_W:0]        rem_sh;
    dim_t                  rem_nx, mod_res, a0_inc;

    assign iu_cur   = iu_reg[axis_reg];
    assign size_cur = axis_reg ? h_eff : w_eff;
    assign wrap_cur = axis_reg ? vwrap_reg : uwrap_reg;
    assign in_range = (iu_cur >= 0) &&
                      ((IUW+1)'(iu_cur) < {{(IUW+1-DIM_W){1'b0}}, size_cur});
    assign rem_sh   = {rem_reg, mag_reg[IUW-1]};
    assign rem_nx   = (rem_sh >= {1'b0, size_cur}) ? DIM_W'(rem_sh - {1'b0, size_cur})
                                                   : rem_sh[DIM_W-1:0];
    assign mod_res  = (neg_reg && rem_nx != '0) ? size_cur - rem_nx : rem_nx;
    assign a0_inc   = a0_reg[axis_reg] + 9'd1;

    // store addressing
    logic [31:0]    rd_full, wr_full;
    logic [RBW:0]   tex_sum;
    logic [1:0]     k_last;
    logic           s_accept, wr_en;
    logic [AC:0]    rnd;

    assign k_last   = filter_reg ? 2'd3 : 2'd0;
    assign tex_sum  = {1'b0, rb_reg[k_reg[1]]} + (RBW+1)'(k_reg[0] ? a1_reg[0] : a0_reg[0]);
    assign rd_full  = 32'(tex_sum) * 32'(MAX_COMPONENTS) + 32'(c_reg);
    assign wr_full  = 32'(s_axis_tdata[15:0]) * 32'(MAX_COMPONENTS)
                    + 32'(s_axis_tdata[17:16]);
    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign wr_en    = s_accept && (s_axis_tuser == ACT_WRITE)
                    && (32'(s_axis_tdata[15:0]) < 32'(TEXELS))
                    && (32'(s_axis_tdata[17:16]) < 32'(MAX_COMPONENTS));
    assign rnd      = {1'b0, acc_reg} + ((AC+1)'(1) << (2 * WB - 1));

    tsb_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_full[AW-1:0]),
        .wdata (s_axis_tdata[33:18]),
        .raddr (rd_full[AW-1:0]),
        .rdata (ram_rdata)
    );

    logic out_free;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            axis_reg    <= 1'b0;
            k_reg       <= '0;
            c_reg       <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready && !(state_reg == S_OUT))
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_accept && s_axis_tuser == ACT_SAMPLE)
                    begin
                        u_reg     <= s_axis_tdata[53:34];
                        v_reg     <= s_axis_tdata[73:54];
                        state_reg <= S_MU;
                    end
                end
                S_MU:
                begin
                    su_reg    <= prod[SW-1:0];
                    state_reg <= S_MV;
                end
                S_MV:
                begin
                    sv_reg    <= prod[SW-1:0];
                    iu_reg[0] <= sp[SW-1:16];
                    f_reg[0]  <= filter_reg ? sp[15 -: WB] : '0;
                    state_reg <= S_AY;
                end
                S_AY:
                begin
                    iu_reg[1] <= sp[SW-1:16];
                    f_reg[1]  <= filter_reg ? sp[15 -: WB] : '0;
                    axis_reg  <= 1'b0;
                    state_reg <= S_AX;
                end
                S_AX:
                begin
                    if (wrap_cur && !in_range)
                    begin
                        neg_reg   <= iu_cur < 0;
                        mag_reg   <= (iu_cur < 0) ? IUW'(-iu_cur) : IUW'(iu_cur);
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_MOD;
                    end
                    else
                    begin
                        a0_reg[axis_reg] <= clamp_idx((IUW+1)'(iu_cur), size_cur);
                        state_reg        <= S_FIN;
                    end
                end
                S_MOD:
                begin
                    rem_reg <= rem_nx;
                    mag_reg <= mag_reg << 1;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(IUW - 1))
                    begin
                        a0_reg[axis_reg] <= mod_res;
                        state_reg        <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!filter_reg)
                        a1_reg[axis_reg] <= a0_reg[axis_reg];
                    else if (wrap_cur)
                        a1_reg[axis_reg] <= (a0_inc == size_cur) ? '0 : a0_inc;
                    else
                        a1_reg[axis_reg] <= clamp_idx((IUW+1)'(iu_cur) + (IUW+1)'(1),
                                                      size_cur);
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_AX;
                    end
                    else
                        state_reg <= S_RB0;
                end
                S_RB0:
                begin
                    rb_reg[0] <= prod[RBW-1:0];
                    state_reg <= S_RB1;
                end
                S_RB1:
                begin
                    rb_reg[1] <= prod[RBW-1:0];
                    k_reg     <= '0;
                    state_reg <= S_WG;
                end
                S_WG:
                begin
                    wt_reg[k_reg] <= prod[B-1:0];
                    k_reg         <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        c_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= S_FA;
                    end
                end
                S_FA:
                begin
                    state_reg <= S_FD;
                end
                S_FD:
                begin
                    acc_reg <= acc_reg + prod[AC-1:0];
                    if (k_reg == k_last)
                        state_reg <= S_OUT;
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= S_FA;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= (rnd[AC:2*WB] > (AC+1-2*WB)'(16'hFFFF))
                                     ? 16'hFFFF : rnd[2*WB +: VALUE_W];
                        m_num_reg   <= c_reg;
                        m_last_reg  <= (3'(c_reg) == nc_eff - 3'd1);
                        k_reg       <= '0;
                        acc_reg     <= '0;
                        if (3'(c_reg) == nc_eff - 3'd1)
                            state_reg <= S_IDLE;
                        else
                        begin
                            c_reg     <= c_reg + 2'd1;
                            state_reg <= S_FA;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_num_reg;
    assign m_axis_tlast  = m_last_reg;

    a_mod_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (cnt_reg < 4'(IUW)))
        else $error("modulo step count overrun");

    a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FD) |-> ($past(state_reg) == S_FA))
        else $error("read data used without address cycle");

    a_fetch_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FA) |-> (k_reg <= k_last))
        else $error("fetch index beyond filter footprint");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !axis_reg) |-> (a0_reg[0] < w_eff))
        else $error("column index outside texture");
endmodule
